// File: rtl/core/tpsr_pkg.sv
package tpsr_pkg;

   // record store size and derived widths
   localparam int RECORD_SLOTS = 32;
   localparam int CNT_W        = $clog2(RECORD_SLOTS + 1);
   localparam int SLOT_W       = 5;

   // duplicate window: 32-bit max over 100
   localparam logic [31:0] DUP_WINDOW = 32'(64'hFFFF_FFFF / 100);

   // queue between front and back
   localparam int QDEPTH  = 4;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W  = $clog2(QDEPTH + 1);

   // configuration register indexes
   localparam logic CSR_SKIP_DUP    = 1'b0;
   localparam logic CSR_COUNT_EMPTY = 1'b1;

   typedef enum logic [1:0] {
      ACT_STORED = 2'd0,
      ACT_DUP    = 2'd1,
      ACT_EMPTY  = 2'd2,
      ACT_FULL   = 2'd3
   } action_type;

   typedef struct packed {
      logic skip_dup;
      logic count_empty;
   } cfg_type;

   // one classified item in the queue
   typedef struct packed {
      logic        flow_start;
      logic        dir;
      logic [31:0] seq;
      logic [31:0] ack;
      logic [15:0] len;
      logic [7:0]  flags;
      logic [63:0] ts;
      logic        empty_skip;
   } entry_type;

   typedef struct packed {
      logic [QCNT_W-1:0] count;
      logic              full;
   } q_stat_type;

endpackage

// File: rtl/core/tcp_packet_stats_recorder_top.sv
// An accepted item passes through a queue entry, then the result register.
// Throughput: one item per cycle while the result side is ready; the combinational
// compare and state update in the back end set that rate, and a 4-entry queue absorbs
// result-side stalls. Reset (synchronous, active high) clears flow state, record count,
// configuration, the queue and the result valid.
module tcp_packet_stats_recorder_top import tpsr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_flow_start,
   input  logic              req_direction,
   input  logic [31:0]       req_seq_number,
   input  logic [31:0]       req_ack_number,
   input  logic [15:0]       req_payload_length,
   input  logic [7:0]        req_tcp_flag_bits,
   input  logic [63:0]       req_timestamp,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_action,
   output logic [SLOT_W-1:0] rsp_slot,
   output logic [15:0]       rsp_rec_length,
   output logic [7:0]        rsp_rec_flags,
   output logic [63:0]       rsp_rec_time,
   output logic signed [1:0] rsp_rec_dir_sign,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic              csr_wdata
);

   cfg_type    cfg_ff, cfg_in;
   q_stat_type q_stat;
   logic       push;
   entry_type  push_entry;
   logic       pop;
   logic       head_valid;
   entry_type  head_entry;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SKIP_DUP:    cfg_in.skip_dup    = csr_wdata;
            CSR_COUNT_EMPTY: cfg_in.count_empty = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tpsr_front u_front (
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_flow_start     (req_flow_start),
      .req_direction      (req_direction),
      .req_seq_number     (req_seq_number),
      .req_ack_number     (req_ack_number),
      .req_payload_length (req_payload_length),
      .req_tcp_flag_bits  (req_tcp_flag_bits),
      .req_timestamp      (req_timestamp),
      .cfg                (cfg_ff),
      .q_stat             (q_stat),
      .push               (push),
      .push_entry         (push_entry)
   );

   tpsr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .q_stat     (q_stat)
   );

   tpsr_exec u_exec (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .head_valid       (head_valid),
      .head_entry       (head_entry),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_action       (rsp_action),
      .rsp_slot         (rsp_slot),
      .rsp_rec_length   (rsp_rec_length),
      .rsp_rec_flags    (rsp_rec_flags),
      .rsp_rec_time     (rsp_rec_time),
      .rsp_rec_dir_sign (rsp_rec_dir_sign)
   );

`ifndef SYNTHESIS
   // results other than stored carry an all-zero record
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_action != ACT_STORED) |->
      (rsp_slot == '0 && rsp_rec_length == '0 && rsp_rec_flags == '0
       && rsp_rec_time == '0 && rsp_rec_dir_sign == '0))
      else $error("non-stored result with nonzero record");

   // stored results carry +1 or -1 as direction sign
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_action == ACT_STORED) |->
      (rsp_rec_dir_sign == 2'sb01 || rsp_rec_dir_sign == 2'sb11))
      else $error("stored result with bad direction sign");

   // queue fill never passes its depth
   assert property (@(posedge clock) disable iff (reset)
      q_stat.count <= QCNT_W'(QDEPTH))
      else $error("queue overflow");

   // a popped item shows up as a valid result in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid)
      else $error("popped item lost");
`endif

endmodule

// File: rtl/core/tpsr_front.sv
module tpsr_front import tpsr_pkg::*; (
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_flow_start,
   input  logic        req_direction,
   input  logic [31:0] req_seq_number,
   input  logic [31:0] req_ack_number,
   input  logic [15:0] req_payload_length,
   input  logic [7:0]  req_tcp_flag_bits,
   input  logic [63:0] req_timestamp,
   input  cfg_type     cfg,
   input  q_stat_type  q_stat,
   output logic        push,
   output entry_type   push_entry
);

   // accept whenever the queue has room
   assign req_ready = !q_stat.full;
   assign push      = req_valid && !q_stat.full;

   // classify: empty payload that is not to be counted
   always_comb begin
      push_entry.flow_start = req_flow_start;
      push_entry.dir        = req_direction;
      push_entry.seq        = req_seq_number;
      push_entry.ack        = req_ack_number;
      push_entry.len        = req_payload_length;
      push_entry.flags      = req_tcp_flag_bits;
      push_entry.ts         = req_timestamp;
      push_entry.empty_skip = (req_payload_length == 16'd0) && !cfg.count_empty;
   end

endmodule

// File: rtl/core/tpsr_queue.sv
module tpsr_queue import tpsr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  entry_type  push_entry,
   input  logic       pop,
   output logic       head_valid,
   output entry_type  head_entry,
   output q_stat_type q_stat
);

   entry_type         slot_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_valid   = count_ff != '0;
   assign head_entry   = slot_ff[rd_ptr_ff];
   assign q_stat.count = count_ff;
   assign q_stat.full  = count_ff == QCNT_W'(QDEPTH);

endmodule

// File: rtl/core/tpsr_exec.sv
module tpsr_exec import tpsr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              head_valid,
   input  entry_type         head_entry,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_action,
   output logic [SLOT_W-1:0] rsp_slot,
   output logic [15:0]       rsp_rec_length,
   output logic [7:0]        rsp_rec_flags,
   output logic [63:0]       rsp_rec_time,
   output logic signed [1:0] rsp_rec_dir_sign
);

   function automatic logic near_below(input logic [31:0] cur, input logic [31:0] prev);
      logic [31:0] diff;
      diff = prev - cur;
      return (cur <= prev) && (diff <= DUP_WINDOW);
   endfunction

   // per-direction flow state
   logic [31:0]      last_seq_ff [2];
   logic [31:0]      last_ack_ff [2];
   logic [15:0]      last_len_ff [2];
   logic [7:0]       last_flags_ff [2];
   logic [CNT_W-1:0] count_ff, count_in;

   // result register
   logic              out_valid_ff, out_valid_in;
   action_type        action_ff, action_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [15:0]       len_ff, len_in;
   logic [7:0]        flags_ff, flags_in;
   logic [63:0]       time_ff, time_in;
   logic signed [1:0] sign_ff, sign_in;

   logic             fs;
   logic             dir;
   logic [31:0]      eff_seq, eff_ack;
   logic [15:0]      eff_len;
   logic [7:0]       eff_flags;
   logic [CNT_W-1:0] eff_count;
   logic             is_dup;
   logic             is_full;

   // take the head when the result register is free or drains now
   assign pop = head_valid && (!out_valid_ff || rsp_ready);

   // state seen after an optional flow-start clear
   always_comb begin
      fs        = head_entry.flow_start;
      dir       = head_entry.dir;
      eff_seq   = fs ? '0 : last_seq_ff[dir];
      eff_ack   = fs ? '0 : last_ack_ff[dir];
      eff_len   = fs ? '0 : last_len_ff[dir];
      eff_flags = fs ? '0 : last_flags_ff[dir];
      eff_count = fs ? '0 : count_ff;
      is_dup    = cfg.skip_dup
                  && near_below(head_entry.seq, eff_seq)
                  && near_below(head_entry.ack, eff_ack)
                  && (eff_count != '0)
                  && (head_entry.len == eff_len)
                  && (head_entry.flags == eff_flags);
      is_full   = eff_count >= CNT_W'(RECORD_SLOTS);
   end

   // action and result fields
   always_comb begin
      count_in = count_ff;
      slot_in  = '0;
      len_in   = '0;
      flags_in = '0;
      time_in  = '0;
      sign_in  = '0;
      if (is_dup) begin
         action_in = ACT_DUP;
         count_in  = eff_count;
      end else if (head_entry.empty_skip) begin
         action_in = ACT_EMPTY;
         count_in  = eff_count;
      end else if (is_full) begin
         action_in = ACT_FULL;
         count_in  = eff_count;
      end else begin
         action_in = ACT_STORED;
         count_in  = eff_count + CNT_W'(1);
         slot_in   = SLOT_W'(eff_count);
         len_in    = head_entry.len;
         flags_in  = head_entry.flags;
         time_in   = head_entry.ts;
         sign_in   = dir ? 2'sb01 : 2'sb11;
      end
      out_valid_in = pop || (out_valid_ff && !rsp_ready);
   end

   // flow state update
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 2; i++) begin
            last_seq_ff[i]   <= '0;
            last_ack_ff[i]   <= '0;
            last_len_ff[i]   <= '0;
            last_flags_ff[i] <= '0;
         end
         count_ff <= '0;
      end else if (pop) begin
         if (fs) begin
            last_seq_ff[!dir]   <= '0;
            last_ack_ff[!dir]   <= '0;
            last_len_ff[!dir]   <= '0;
            last_flags_ff[!dir] <= '0;
         end
         if (!is_dup) begin
            last_seq_ff[dir]   <= head_entry.seq;
            last_ack_ff[dir]   <= head_entry.ack;
            last_len_ff[dir]   <= head_entry.len;
            last_flags_ff[dir] <= head_entry.flags;
         end
         count_ff <= count_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         action_ff <= action_in;
         slot_ff   <= slot_in;
         len_ff    <= len_in;
         flags_ff  <= flags_in;
         time_ff   <= time_in;
         sign_ff   <= sign_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_action       = action_ff;
   assign rsp_slot         = slot_ff;
   assign rsp_rec_length   = len_ff;
   assign rsp_rec_flags    = flags_ff;
   assign rsp_rec_time     = time_ff;
   assign rsp_rec_dir_sign = sign_ff;

endmodule

// File: verif/tpsr_tb_pkg.sv
`timescale 1ns / 1ps
package tpsr_tb_pkg;
   import tpsr_pkg::*;

   // one TCP packet as sent on the request side
   typedef struct {
      logic        flow_start;
      logic        direction;
      logic [31:0] seq;
      logic [31:0] ack;
      logic [15:0] len;
      logic [7:0]  flags;
      logic [63:0] ts;
   } packet_type;

   // one result: action plus the record fields
   typedef struct {
      action_type        action;
      logic [SLOT_W-1:0] slot;
      logic [15:0]       len;
      logic [7:0]        flags;
      logic [63:0]       ts;
      logic signed [1:0] dir_sign;
   } record_type;

   // Tracks the flow state of the recorder, predicts the result of every
   // accepted packet and checks the results in order.
   class record_book;
      logic [31:0] last_seq [2];
      logic [31:0] last_ack [2];
      logic [15:0] last_len [2];
      logic [7:0]  last_flags [2];
      int unsigned stored_count;
      logic        skip_dup;
      logic        count_empty;
      record_type  expected_records [$];
      int unsigned errors;
      int unsigned action_seen [4];

      function new();
         clear_flow();
         skip_dup    = 1'b0;
         count_empty = 1'b0;
         errors      = 0;
         foreach (action_seen[i]) action_seen[i] = 0;
      endfunction

      function void clear_flow();
         for (int d = 0; d < 2; d++) begin
            last_seq[d]   = '0;
            last_ack[d]   = '0;
            last_len[d]   = '0;
            last_flags[d] = '0;
         end
         stored_count = 0;
      endfunction

      function void write_csr(logic index, logic value);
         if (index == CSR_SKIP_DUP) begin
            skip_dup = value;
         end else begin
            count_empty = value;
         end
      endfunction

      // at or below the last value, and no further below than the window
      function bit near_below(logic [31:0] cur, logic [31:0] prev);
         return (cur <= prev) && ((prev - cur) <= DUP_WINDOW);
      endfunction

      function void note_packet(packet_type p);
         record_type r;
         int         d;
         d          = p.direction;
         r.action   = ACT_STORED;
         r.slot     = '0;
         r.len      = '0;
         r.flags    = '0;
         r.ts       = '0;
         r.dir_sign = '0;
         if (p.flow_start) clear_flow();
         if (skip_dup && near_below(p.seq, last_seq[d]) && near_below(p.ack, last_ack[d]) &&
             stored_count != 0 && p.len == last_len[d] && p.flags == last_flags[d]) begin
            // dropped duplicate: state untouched
            r.action = ACT_DUP;
         end else begin
            last_seq[d]   = p.seq;
            last_ack[d]   = p.ack;
            last_len[d]   = p.len;
            last_flags[d] = p.flags;
            if (p.len == 0 && !count_empty) begin
               r.action = ACT_EMPTY;
            end else if (stored_count >= RECORD_SLOTS) begin
               r.action = ACT_FULL;
            end else begin
               r.slot     = SLOT_W'(stored_count);
               r.len      = p.len;
               r.flags    = p.flags;
               r.ts       = p.ts;
               r.dir_sign = p.direction ? 2'sd1 : -2'sd1;
               stored_count++;
            end
         end
         expected_records.push_back(r);
      endfunction

      function void check_field(string name, logic [63:0] expv, logic [63:0] actv);
         if (actv !== expv) begin
            $error("%s mismatch: expected %0h, actual %0h", name, expv, actv);
            errors++;
         end
      endfunction

      function void check_record(record_type got);
         record_type exp;
         if (expected_records.size() == 0) begin
            $error("result with no packet outstanding: action %0d", got.action);
            errors++;
            return;
         end
         exp = expected_records.pop_front();
         check_field("action", exp.action, got.action);
         check_field("slot", exp.slot, got.slot);
         check_field("rec_length", exp.len, got.len);
         check_field("rec_flags", exp.flags, got.flags);
         check_field("rec_time", exp.ts, got.ts);
         check_field("rec_dir_sign", exp.dir_sign, got.dir_sign);
         action_seen[exp.action]++;
      endfunction

      function int pending();
         return expected_records.size();
      endfunction
   endclass

endpackage

// File: verif/tb_tcp_packet_stats_recorder_top.sv
`timescale 1ns / 1ps
module tb_tcp_packet_stats_recorder_top;
   import tpsr_pkg::*;
   import tpsr_tb_pkg::*;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic              req_flow_start;
   logic              req_direction;
   logic [31:0]       req_seq_number;
   logic [31:0]       req_ack_number;
   logic [15:0]       req_payload_length;
   logic [7:0]        req_tcp_flag_bits;
   logic [63:0]       req_timestamp;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [1:0]        rsp_action;
   logic [SLOT_W-1:0] rsp_slot;
   logic [15:0]       rsp_rec_length;
   logic [7:0]        rsp_rec_flags;
   logic [63:0]       rsp_rec_time;
   logic signed [1:0] rsp_rec_dir_sign;
   logic              csr_we;
   logic              csr_index;
   logic              csr_wdata;

   record_book  records;

   // packet generator shadow of each direction
   logic [31:0] gen_seq [2];
   logic [31:0] gen_ack [2];
   logic [15:0] gen_len [2];
   logic [7:0]  gen_flags [2];
   logic [63:0] gen_ts;
   bit          tx_fast;
   bit          rx_fast;
   int unsigned pkt_count;
   int unsigned flow_count;
   int unsigned cfg_count;

   tcp_packet_stats_recorder_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_flow_start     (req_flow_start),
      .req_direction      (req_direction),
      .req_seq_number     (req_seq_number),
      .req_ack_number     (req_ack_number),
      .req_payload_length (req_payload_length),
      .req_tcp_flag_bits  (req_tcp_flag_bits),
      .req_timestamp      (req_timestamp),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_action         (rsp_action),
      .rsp_slot           (rsp_slot),
      .rsp_rec_length     (rsp_rec_length),
      .rsp_rec_flags      (rsp_rec_flags),
      .rsp_rec_time       (rsp_rec_time),
      .rsp_rec_dir_sign   (rsp_rec_dir_sign),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic packet_type make_packet(logic fs, logic d, logic [31:0] seq,
                                              logic [31:0] ack, logic [15:0] len,
                                              logic [7:0] flags, logic [63:0] ts);
      packet_type p;
      p.flow_start = fs;
      p.direction  = d;
      p.seq        = seq;
      p.ack        = ack;
      p.len        = len;
      p.flags      = flags;
      p.ts         = ts;
      return p;
   endfunction

   // offset below the last value, mostly inside the duplicate window
   function automatic logic [31:0] back_off();
      case ($urandom_range(0, 9))
         0, 1, 2: return '0;
         3, 4, 5: return 32'($urandom_range(1, 5000));
         6:       return DUP_WINDOW;
         7:       return DUP_WINDOW + 32'd1;
         8:       return 32'd0 - 32'($urandom_range(1, 5000));
         default: return $urandom;
      endcase
   endfunction

   // hand one item to the block; valid stays up through a zero gap
   task automatic send_packet(input packet_type p);
      int gap;
      gap = tx_fast ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_flow_start     <= p.flow_start;
      req_direction      <= p.direction;
      req_seq_number     <= p.seq;
      req_ack_number     <= p.ack;
      req_payload_length <= p.len;
      req_tcp_flag_bits  <= p.flags;
      req_timestamp      <= p.ts;
      do @(posedge clock); while (req_ready !== 1'b1);
      records.note_packet(p);
      pkt_count++;
   endtask

   // stop sending and wait until every result is back
   task automatic settle();
      req_valid <= 1'b0;
      while (records.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // both registers, written back to back while idle
   task automatic set_config(input logic skip, input logic empty);
      settle();
      csr_we    <= 1'b1;
      csr_index <= CSR_SKIP_DUP;
      csr_wdata <= skip;
      @(posedge clock);
      records.write_csr(CSR_SKIP_DUP, skip);
      csr_index <= CSR_COUNT_EMPTY;
      csr_wdata <= empty;
      @(posedge clock);
      records.write_csr(CSR_COUNT_EMPTY, empty);
      csr_we <= 1'b0;
      cfg_count++;
   endtask

   task automatic run_directed();
      logic [31:0] edge_val;
      edge_val = 32'hFFFF_FFFF - DUP_WINDOW;
      set_config(1'b1, 1'b0);
      tx_fast = 1'b0;
      // all-ones packet, exact repeat, then the window edge and one past it
      send_packet(make_packet(1, 0, '1, '1, 16'hFFFF, 8'hFF, '1));
      send_packet(make_packet(0, 0, '1, '1, 16'hFFFF, 8'hFF, '1));
      send_packet(make_packet(0, 0, edge_val, edge_val, 16'hFFFF, 8'hFF, 64'd1));
      send_packet(make_packet(0, 0, edge_val - 1, edge_val, 16'hFFFF, 8'hFF, 64'd2));
      // flag byte differs, then length differs
      send_packet(make_packet(0, 0, edge_val - 1, edge_val, 16'hFFFF, 8'hFE, 64'd3));
      send_packet(make_packet(0, 0, edge_val - 1, edge_val, 16'hFFFE, 8'hFE, 64'd4));
      // reverse side still at zero: an all-zero packet looks like a repeat
      send_packet(make_packet(0, 1, '0, '0, 16'd0, 8'h00, '0));
      send_packet(make_packet(0, 1, 32'd5, '0, 16'd0, 8'h12, 64'd5));
      send_packet(make_packet(0, 1, 32'd5, '0, 16'd0, 8'h12, 64'd6));
      // flow start clears the count, so no duplicate drop
      send_packet(make_packet(1, 1, 32'd5, '0, 16'd0, 8'h12, 64'd7));
      send_packet(make_packet(0, 1, 32'h1234_5678, 32'h9ABC_DEF0, 16'd1, 8'h01,
                              64'h0123_4567_89AB_CDEF));
      // below the last value by more than the duplicate window
      send_packet(make_packet(0, 1, 32'd0, 32'h9ABC_DEF0, 16'd1, 8'h01, 64'd8));
      set_config(1'b0, 1'b1);
      // empty payloads recorded, repeats kept with the drop disabled
      send_packet(make_packet(1, 0, 32'd100, 32'd200, 16'd0, 8'h10, 64'hFFFF_0000_FFFF_0000));
      send_packet(make_packet(0, 0, 32'd100, 32'd200, 16'd0, 8'h10, 64'h0000_FFFF_0000_FFFF));
      send_packet(make_packet(0, 1, '0, '0, 16'd0, 8'h00, '0));
      send_packet(make_packet(0, 1, '1, '1, 16'hFFFF, 8'hFF, '1));
      flow_count += 3;
   endtask

   // one flow: mostly in-order data with retransmits and pure acks, some noise
   task automatic run_flow(input int n_pkts);
      packet_type p;
      int         d;
      int         kind;
      tx_fast = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < 2; k++) begin
         gen_seq[k]   = $urandom;
         gen_ack[k]   = $urandom;
         gen_len[k]   = '0;
         gen_flags[k] = 8'h02;
      end
      gen_ts = {$urandom, $urandom};
      flow_count++;
      for (int i = 0; i < n_pkts; i++) begin
         d            = $urandom_range(0, 1);
         kind         = $urandom_range(0, 99);
         gen_ts       = gen_ts + 64'($urandom_range(1, 100000));
         p.flow_start = (i == 0);
         p.direction  = d;
         p.ts         = gen_ts;
         if (kind < 50) begin
            // in-order data segment
            p.seq   = gen_seq[d] + 32'(gen_len[d]);
            p.ack   = gen_ack[d] + 32'($urandom_range(0, 3000));
            p.len   = ($urandom_range(0, 9) == 0) ? 16'($urandom) :
                      16'($urandom_range(1, 1460));
            p.flags = 8'($urandom);
         end else if (kind < 70) begin
            // retransmit of the last segment of this side
            p.seq   = gen_seq[d] - back_off();
            p.ack   = gen_ack[d] - back_off();
            p.len   = gen_len[d];
            p.flags = gen_flags[d];
            if ($urandom_range(0, 9) == 0) p.flags[$urandom_range(0, 7)] ^= 1'b1;
         end else if (kind < 85) begin
            // pure acknowledgment
            p.seq   = gen_seq[d] + 32'(gen_len[d]);
            p.ack   = gen_ack[d] + 32'($urandom_range(0, 3000));
            p.len   = '0;
            p.flags = 8'($urandom);
         end else begin
            // noise, now and then a stray flow start
            p.flow_start = p.flow_start | ($urandom_range(0, 7) == 0);
            p.seq        = $urandom;
            p.ack        = $urandom;
            p.len        = 16'($urandom);
            p.flags      = 8'($urandom);
            p.ts         = {$urandom, $urandom};
         end
         if (kind < 50 || (kind >= 70 && kind < 85)) begin
            gen_seq[d]   = p.seq;
            gen_ack[d]   = p.ack;
            gen_len[d]   = p.len;
            gen_flags[d] = p.flags;
         end
         send_packet(p);
      end
   endtask

   // result side: random stalls per item, with stretches of none
   initial begin
      record_type got;
      int         stall;
      int         rx_count;
      rsp_ready <= 1'b0;
      rx_count = 0;
      @(posedge clock);
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (rx_count % 40 == 0) rx_fast = ($urandom_range(0, 2) == 0);
         stall = rx_fast ? 0 : $urandom_range(0, 15);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         got.action   = action_type'(rsp_action);
         got.slot     = rsp_slot;
         got.len      = rsp_rec_length;
         got.flags    = rsp_rec_flags;
         got.ts       = rsp_rec_time;
         got.dir_sign = rsp_rec_dir_sign;
         records.check_record(got);
         rx_count++;
      end
   end

   // main sequence
   initial begin
      logic        skip;
      logic        empty;
      int unsigned target;
      int          n;
      bit          paused;
      records            = new();
      pkt_count          = 0;
      flow_count         = 0;
      cfg_count          = 0;
      paused             = 1'b0;
      tx_fast            = 1'b0;
      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_flow_start     <= 1'b0;
      req_direction      <= 1'b0;
      req_seq_number     <= '0;
      req_ack_number     <= '0;
      req_payload_length <= '0;
      req_tcp_flag_bits  <= '0;
      req_timestamp      <= '0;
      csr_we             <= 1'b0;
      csr_index          <= CSR_SKIP_DUP;
      csr_wdata          <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();

      // random flows under each register setting, the last two drawn at random
      for (int ph = 0; ph < 6; ph++) begin
         if (ph < 4) begin
            skip  = ph[0];
            empty = ph[1];
         end else begin
            skip  = $urandom_range(0, 1);
            empty = $urandom_range(0, 1);
         end
         set_config(skip, empty);
         target = pkt_count + 183;
         while (pkt_count < target) begin
            n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 10) : $urandom_range(40, 90);
            // last flow of a phase is cut to the phase budget
            if (n > int'(target - pkt_count)) n = int'(target - pkt_count);
            run_flow(n);
            // hold off the sender once until the block has drained
            if (ph == 2 && !paused) begin
               settle();
               paused = 1'b1;
            end
         end
      end

      settle();
      repeat (10) @(posedge clock);
      $display("covered %0d packets in %0d flows under %0d register settings",
               pkt_count, flow_count, cfg_count);
      $display("results: %0d stored, %0d duplicates dropped, %0d empty skipped, %0d full",
               records.action_seen[ACT_STORED], records.action_seen[ACT_DUP],
               records.action_seen[ACT_EMPTY], records.action_seen[ACT_FULL]);
      if (records.errors == 0 && records.pending() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("timeout with %0d results outstanding", records.pending());
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// File: files.f
rtl/core/tpsr_pkg.sv
rtl/core/tpsr_front.sv
rtl/core/tpsr_queue.sv
rtl/core/tpsr_exec.sv
rtl/core/tcp_packet_stats_recorder_top.sv
verif/tpsr_tb_pkg.sv
verif/tb_tcp_packet_stats_recorder_top.sv
